// ===== design/midi_track_event_parser_macros.svh =====
// Assertion macros shared by the track event parser RTL.
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MTEP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define MTEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mtep_pkg.sv =====
// Types and constants for the MIDI track event parser.
`default_nettype none

package mtep_pkg;

  localparam int DELTA_W   = 28;
  localparam int OUT_LEN_W = 28;

  localparam logic [2:0] KIND_CHANNEL = 3'd0;
  localparam logic [2:0] KIND_META    = 3'd1;
  localparam logic [2:0] KIND_SYSEX   = 3'd2;
  localparam logic [2:0] KIND_ESCAPE  = 3'd3;
  localparam logic [2:0] KIND_SYSTEM  = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_NO_RUNNING = 2'd1;
  localparam logic [1:0] ERR_VARINT     = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

  localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
  localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
  localparam logic [7:0] STATUS_META   = 8'hFF;
  localparam logic [7:0] STATUS_SYS    = 8'hF0;
  localparam logic [3:0] GROUP_PROGRAM = 4'hC;
  localparam logic [3:0] GROUP_PRESSURE = 4'hD;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       chunk_end;
  } mtep_item_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [DELTA_W-1:0]   delta_ticks;
    logic [7:0]           status_code;
    logic [3:0]           channel_num;
    logic [6:0]           data_first;
    logic [6:0]           data_second;
    logic [7:0]           payload_byte;
    logic [OUT_LEN_W-1:0] payload_index;
    logic [OUT_LEN_W-1:0] payload_len;
    logic                 has_payload;
    logic                 event_last;
    logic [1:0]           error_code;
  } mtep_result_t;

endpackage

`default_nettype wire

// ===== design/mtep_in_stage.sv =====
// Input register stage of the MIDI track event parser.
`default_nettype none

module mtep_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [7:0]         byte_in,
  input  wire logic               chunk_end,
  input  wire logic               advance,
  output logic                    in_stall,
  output logic                    item_valid,
  output mtep_pkg::mtep_item_t    item
);

  logic load;

  assign in_stall = item_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.byte_val  <= byte_in;
      item.chunk_end <= chunk_end;
    end
  end

endmodule

`default_nettype wire

// ===== design/mtep_parser.sv =====
// Parse state and single-step event decode of the MIDI track event parser.
`default_nettype none

module mtep_parser #(
  parameter int MAX_VARINT_BYTES = 4,
  parameter int LENGTH_BITS      = 28
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire mtep_pkg::mtep_item_t   item,
  output mtep_pkg::mtep_result_t      result,
  output logic                        result_valid
);

  localparam int VC_W  = $clog2(MAX_VARINT_BYTES + 1);
  localparam int LB    = LENGTH_BITS;
  localparam int DW    = mtep_pkg::DELTA_W;
  localparam int OW    = mtep_pkg::OUT_LEN_W;

  localparam logic [2:0] PH_DELTA   = 3'd0;
  localparam logic [2:0] PH_STATUS  = 3'd1;
  localparam logic [2:0] PH_DATA1   = 3'd2;
  localparam logic [2:0] PH_DATA2   = 3'd3;
  localparam logic [2:0] PH_MTYPE   = 3'd4;
  localparam logic [2:0] PH_LEN     = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_SXEND   = 3'd7;

  logic [2:0]      phase, phase_next;
  logic [DW-1:0]   delta_accum, delta_accum_next;
  logic [VC_W-1:0] varint_count, varint_count_next;
  logic [7:0]      running_status_byte, running_status_byte_next;
  logic            running_status_valid, running_status_valid_next;
  logic [7:0]      current_status, current_status_next;
  logic [6:0]      held_data, held_data_next;
  logic [LB-1:0]   length_accum, length_accum_next;
  logic [LB-1:0]   payload_counter, payload_counter_next;
  logic [2:0]      event_kind, event_kind_next;

  logic [7:0]      b;
  logic            vc_full;
  logic [VC_W-1:0] vc_inc;
  logic [DW-1:0]   delta_base, delta_new;
  logic [LB-1:0]   len_base, len_new, plen_new, plen;
  logic [LB:0]     cnt_inc;
  logic            done;
  logic            is_sysex;

  function automatic mtep_pkg::mtep_result_t error_res(input logic [1:0] code);
    mtep_pkg::mtep_result_t r;
    r            = '0;
    r.kind       = mtep_pkg::KIND_ERROR;
    r.event_last = 1'b1;
    r.error_code = code;
    return r;
  endfunction

  function automatic mtep_pkg::mtep_result_t channel_res(
    input logic [DW-1:0] delta, input logic [7:0] status,
    input logic [6:0] d1, input logic [6:0] d2);
    mtep_pkg::mtep_result_t r;
    r             = '0;
    r.kind        = mtep_pkg::KIND_CHANNEL;
    r.delta_ticks = delta;
    r.status_code = status;
    r.channel_num = status[3:0];
    r.data_first  = d1;
    r.data_second = d2;
    r.event_last  = 1'b1;
    return r;
  endfunction

  function automatic mtep_pkg::mtep_result_t payload_res(
    input logic [2:0] knd, input logic [DW-1:0] delta, input logic [7:0] status,
    input logic [7:0] pbyte, input logic [OW-1:0] idx, input logic [OW-1:0] len,
    input logic has, input logic last);
    mtep_pkg::mtep_result_t r;
    r               = '0;
    r.kind          = knd;
    r.delta_ticks   = delta;
    r.status_code   = status;
    r.payload_byte  = has ? pbyte : 8'h00;
    r.payload_index = idx;
    r.payload_len   = len;
    r.has_payload   = has;
    r.event_last    = last;
    return r;
  endfunction

  function automatic logic two_data(input logic [7:0] status);
    return (status[7:4] != mtep_pkg::GROUP_PROGRAM) &&
           (status[7:4] != mtep_pkg::GROUP_PRESSURE);
  endfunction

  assign b          = item.byte_val;
  assign is_sysex   = (event_kind == mtep_pkg::KIND_SYSEX);
  assign vc_full    = (varint_count >= VC_W'(MAX_VARINT_BYTES));
  assign vc_inc     = varint_count + VC_W'(1);
  assign delta_base = (varint_count == '0) ? '0 : delta_accum;
  assign delta_new  = DW'({delta_base, b[6:0]});
  assign len_base   = (varint_count == '0) ? '0 : length_accum;
  assign len_new    = LB'({len_base, b[6:0]});
  assign plen_new   = (is_sysex && len_new != '0) ? len_new - LB'(1) : len_new;
  assign plen       = (is_sysex && length_accum != '0) ? length_accum - LB'(1) : length_accum;
  assign cnt_inc    = {1'b0, payload_counter} + (LB + 1)'(1);
  assign done       = (cnt_inc >= {1'b0, plen});

  always_comb begin
    phase_next                = phase;
    delta_accum_next          = delta_accum;
    varint_count_next         = varint_count;
    running_status_byte_next  = running_status_byte;
    running_status_valid_next = running_status_valid;
    current_status_next       = current_status;
    held_data_next            = held_data;
    length_accum_next         = length_accum;
    payload_counter_next      = payload_counter;
    event_kind_next           = event_kind;
    result                    = '0;
    result_valid              = 1'b0;

    unique case (phase)
      PH_STATUS: begin
        if (b < 8'h80) begin
          if (!running_status_valid) begin
            result            = error_res(mtep_pkg::ERR_NO_RUNNING);
            result_valid      = 1'b1;
            phase_next        = PH_DELTA;
            varint_count_next = '0;
          end else begin
            current_status_next = running_status_byte;
            if (two_data(running_status_byte)) begin
              held_data_next = b[6:0];
              phase_next     = PH_DATA2;
            end else begin
              result       = channel_res(delta_accum, running_status_byte, b[6:0], 7'd0);
              result_valid = 1'b1;
              phase_next   = PH_DELTA;
            end
          end
        end else if (b < mtep_pkg::STATUS_SYS) begin
          running_status_byte_next  = b;
          running_status_valid_next = 1'b1;
          current_status_next       = b;
          phase_next                = PH_DATA1;
        end else begin
          running_status_byte_next  = 8'h00;
          running_status_valid_next = 1'b0;
          current_status_next       = b;
          varint_count_next         = '0;
          if (b == mtep_pkg::STATUS_META) begin
            event_kind_next = mtep_pkg::KIND_META;
            phase_next      = PH_MTYPE;
          end else if (b == mtep_pkg::STATUS_SYSEX) begin
            event_kind_next = mtep_pkg::KIND_SYSEX;
            phase_next      = PH_LEN;
          end else if (b == mtep_pkg::STATUS_ESCAPE) begin
            event_kind_next = mtep_pkg::KIND_ESCAPE;
            phase_next      = PH_LEN;
          end else begin
            result             = '0;
            result.kind        = mtep_pkg::KIND_SYSTEM;
            result.delta_ticks = delta_accum;
            result.status_code = b;
            result.event_last  = 1'b1;
            result_valid       = 1'b1;
            phase_next         = PH_DELTA;
          end
        end
      end
      PH_DATA1: begin
        if (two_data(current_status)) begin
          held_data_next = b[6:0];
          phase_next     = PH_DATA2;
        end else begin
          result       = channel_res(delta_accum, current_status, b[6:0], 7'd0);
          result_valid = 1'b1;
          phase_next   = PH_DELTA;
        end
      end
      PH_DATA2: begin
        result       = channel_res(delta_accum, current_status, held_data, b[6:0]);
        result_valid = 1'b1;
        phase_next   = PH_DELTA;
      end
      PH_MTYPE: begin
        current_status_next = b;
        varint_count_next   = '0;
        phase_next          = PH_LEN;
      end
      PH_LEN: begin
        if (vc_full) begin
          result            = error_res(mtep_pkg::ERR_VARINT);
          result_valid      = 1'b1;
          phase_next        = PH_DELTA;
          varint_count_next = '0;
        end else begin
          length_accum_next = len_new;
          varint_count_next = vc_inc;
          if (!b[7]) begin
            varint_count_next    = '0;
            payload_counter_next = '0;
            if (is_sysex && len_new != '0 && plen_new == '0) begin
              phase_next = PH_SXEND;
            end else if (plen_new == '0) begin
              result       = payload_res(event_kind, delta_accum, current_status, 8'h00,
                                         '0, OW'(plen_new), 1'b0, 1'b1);
              result_valid = 1'b1;
              phase_next   = PH_DELTA;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        payload_counter_next = LB'(cnt_inc);
        result       = payload_res(event_kind, delta_accum, current_status, b,
                                   OW'(payload_counter), OW'(plen), 1'b1,
                                   done && !is_sysex);
        result_valid = 1'b1;
        if (done) begin
          phase_next = is_sysex ? PH_SXEND : PH_DELTA;
        end
      end
      PH_SXEND: begin
        result            = payload_res(event_kind, delta_accum, current_status, 8'h00,
                                        OW'(plen), OW'(plen), 1'b0, 1'b1);
        result_valid      = 1'b1;
        phase_next        = PH_DELTA;
        varint_count_next = '0;
        if (b != mtep_pkg::STATUS_ESCAPE) begin
          // terminator missing: this byte opens the next delta
          delta_accum_next  = DW'(b[6:0]);
          varint_count_next = VC_W'(1);
          if (!b[7]) begin
            varint_count_next = '0;
            phase_next        = PH_STATUS;
          end
        end
      end
      default: begin
        if (vc_full) begin
          result            = error_res(mtep_pkg::ERR_VARINT);
          result_valid      = 1'b1;
          phase_next        = PH_DELTA;
          varint_count_next = '0;
        end else begin
          delta_accum_next  = delta_new;
          varint_count_next = vc_inc;
          if (!b[7]) begin
            varint_count_next = '0;
            phase_next        = PH_STATUS;
          end
        end
      end
    endcase

    if (item.chunk_end) begin
      if (phase_next != PH_DELTA || varint_count_next != '0) begin
        result       = error_res(mtep_pkg::ERR_TRUNCATED);
        result_valid = 1'b1;
      end
      phase_next                = PH_DELTA;
      delta_accum_next          = '0;
      varint_count_next         = '0;
      running_status_byte_next  = 8'h00;
      running_status_valid_next = 1'b0;
      current_status_next       = 8'h00;
      held_data_next            = 7'd0;
      length_accum_next         = '0;
      payload_counter_next      = '0;
      event_kind_next           = mtep_pkg::KIND_CHANNEL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_DELTA;
      delta_accum          <= '0;
      varint_count         <= '0;
      running_status_byte  <= 8'h00;
      running_status_valid <= 1'b0;
      current_status       <= 8'h00;
      held_data            <= 7'd0;
      length_accum         <= '0;
      payload_counter      <= '0;
      event_kind           <= mtep_pkg::KIND_CHANNEL;
    end else if (step) begin
      phase                <= phase_next;
      delta_accum          <= delta_accum_next;
      varint_count         <= varint_count_next;
      running_status_byte  <= running_status_byte_next;
      running_status_valid <= running_status_valid_next;
      current_status       <= current_status_next;
      held_data            <= held_data_next;
      length_accum         <= length_accum_next;
      payload_counter      <= payload_counter_next;
      event_kind           <= event_kind_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/midi_track_event_parser.sv =====
// Top level of the MIDI track event parser: input stage, parse step, result register.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one byte of a track chunk per
//   transaction, chunk_end set on the chunk's last byte. Output channel
//   (out_valid / out_stall) gives at most one event result per input byte:
//   a channel message, a system event, one payload byte of a meta, sysex or
//   escape event, an empty meta, sysex or escape event, a sysex close, or an error.
//   Each byte is held in the input register, and its result is then held in
//   the result register.
//   Throughput: one byte per cycle while out_stall is low, set by the
//   combinational parse step between the two registers.
//   When out_stall is high with a result held, the parse step pauses; an
//   empty input register still takes one more byte, then in_stall rises.
//   Reset clears both valid flags and returns the parse state to waiting for
//   a delta time with no running status. A byte carrying chunk_end also
//   returns the parse state to that condition.
`default_nettype none
`include "midi_track_event_parser_macros.svh"

module midi_track_event_parser #(
  parameter int MAX_VARINT_BYTES = 4,
  parameter int LENGTH_BITS      = 28
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_in,
  input  wire logic        chunk_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [27:0]      delta_ticks,
  output logic [7:0]       status_code,
  output logic [3:0]       channel_num,
  output logic [6:0]       data_first,
  output logic [6:0]       data_second,
  output logic [7:0]       payload_byte,
  output logic [27:0]      payload_index,
  output logic [27:0]      payload_len,
  output logic             has_payload,
  output logic             event_last,
  output logic [1:0]       error_code
);

  logic                   item_valid;
  mtep_pkg::mtep_item_t   item;
  logic                   advance;
  mtep_pkg::mtep_result_t step_res;
  logic                   step_valid;
  mtep_pkg::mtep_result_t out_res;

  assign advance = item_valid && (!out_valid || !out_stall);

  mtep_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .byte_in    (byte_in),
    .chunk_end  (chunk_end),
    .advance    (advance),
    .in_stall   (in_stall),
    .item_valid (item_valid),
    .item       (item)
  );

  mtep_parser #(
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
    .LENGTH_BITS      (LENGTH_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .item         (item),
    .result       (step_res),
    .result_valid (step_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_valid) begin
      out_res <= step_res;
    end
  end

  assign kind          = out_res.kind;
  assign delta_ticks   = out_res.delta_ticks;
  assign status_code   = out_res.status_code;
  assign channel_num   = out_res.channel_num;
  assign data_first    = out_res.data_first;
  assign data_second   = out_res.data_second;
  assign payload_byte  = out_res.payload_byte;
  assign payload_index = out_res.payload_index;
  assign payload_len   = out_res.payload_len;
  assign has_payload   = out_res.has_payload;
  assign event_last    = out_res.event_last;
  assign error_code    = out_res.error_code;

  `MTEP_ASSERT_NOW(a_error_closes, clk, rst, out_valid && kind == mtep_pkg::KIND_ERROR, event_last && error_code != mtep_pkg::ERR_NONE, "error result malformed")
  `MTEP_ASSERT_NOW(a_code_only_on_error, clk, rst, out_valid && kind != mtep_pkg::KIND_ERROR, error_code == mtep_pkg::ERR_NONE, "error code on non-error result")
  `MTEP_ASSERT_NOW(a_channel_no_payload, clk, rst, out_valid && kind == mtep_pkg::KIND_CHANNEL, !has_payload && payload_len == '0 && event_last, "channel result carries payload")
  `MTEP_ASSERT_NEXT(a_stall_pauses_step, clk, rst, out_valid && out_stall && item_valid, item_valid && out_valid, "parse step ran while result held")

endmodule

`default_nettype wire
